// ===== rtl/hopfield_associative_memory_core_macros.svh =====
// Assertion macros for the Hopfield associative memory core.
`ifndef HOPFIELD_ASSOCIATIVE_MEMORY_CORE_MACROS_SVH
`define HOPFIELD_ASSOCIATIVE_MEMORY_CORE_MACROS_SVH

// same-cycle implication
`define HAMC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HAMC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/hamc_pkg.sv =====
// Shared constants and types for the Hopfield associative memory core.
package hamc_pkg;

  localparam int PAT_BITS        = 25;
  localparam int REQ_W           = 2;
  localparam int NEURONS_DEF     = 25;
  localparam int WEIGHT_BITS_DEF = 8;
  localparam int GROUP           = 8;

  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LEARN  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RECALL = 2'd2;

  typedef struct packed {
    logic clr;
    logic we;
    logic re;
  } wmem_ctl_t;

endpackage

// ===== rtl/hamc_weight_mem.sv =====
// Weight matrix row memory with per-row valid bits; invalid rows read as zero.
module hamc_weight_mem #(
  parameter int NEURONS     = hamc_pkg::NEURONS_DEF,
  parameter int WEIGHT_BITS = hamc_pkg::WEIGHT_BITS_DEF,
  localparam int RW         = $clog2(NEURONS),
  localparam int ROW_W      = NEURONS * WEIGHT_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hamc_pkg::wmem_ctl_t ctl,
  input  logic [RW-1:0]       wr_addr,
  input  logic [ROW_W-1:0]    wr_data,
  input  logic [RW-1:0]       rd_addr,
  output logic [ROW_W-1:0]    rd_data
);
  import hamc_pkg::*;

  logic [ROW_W-1:0]   mem_r [NEURONS];
  logic [NEURONS-1:0] vld_r;
  logic [ROW_W-1:0]   rd_q_r;
  logic               rd_vld_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (ctl.re) begin
      rd_q_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (ctl.clr) begin
        vld_r <= '0;
      end else if (ctl.we) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (ctl.re) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

// ===== rtl/hamc_learn_unit.sv =====
// Hebbian row update: saturating +1/-1 on every off-diagonal weight of one row.
module hamc_learn_unit #(
  parameter int NEURONS     = hamc_pkg::NEURONS_DEF,
  parameter int WEIGHT_BITS = hamc_pkg::WEIGHT_BITS_DEF,
  localparam int RW         = $clog2(NEURONS),
  localparam int ROW_W      = NEURONS * WEIGHT_BITS
) (
  input  logic [RW-1:0]      row_idx,
  input  logic [ROW_W-1:0]   row_data,
  input  logic [NEURONS-1:0] neu,
  output logic [ROW_W-1:0]   row_new
);
  import hamc_pkg::*;

  localparam logic signed [WEIGHT_BITS-1:0] W_MAX = WEIGHT_BITS'((2 ** (WEIGHT_BITS - 1)) - 1);
  localparam logic signed [WEIGHT_BITS-1:0] W_MIN = -W_MAX;

  logic self_bit;

  assign self_bit = neu[row_idx];

  always_comb begin
    logic signed [WEIGHT_BITS-1:0] w;
    row_new = row_data;
    for (int j = 0; j < NEURONS; j++) begin
      w = row_data[j*WEIGHT_BITS +: WEIGHT_BITS];
      if (row_idx != RW'(j)) begin
        if (self_bit == neu[j]) begin
          if (w < W_MAX) begin
            w = w + WEIGHT_BITS'(1);
          end
        end else begin
          if (w > W_MIN) begin
            w = w - WEIGHT_BITS'(1);
          end
        end
      end
      row_new[j*WEIGHT_BITS +: WEIGHT_BITS] = w;
    end
  end

endmodule

// ===== rtl/hamc_recall_unit.sv =====
// Two-stage row dot product: group sums, then total with late correction
// for the neuron decided one row earlier, and the sign decision.
module hamc_recall_unit #(
  parameter int NEURONS     = hamc_pkg::NEURONS_DEF,
  parameter int WEIGHT_BITS = hamc_pkg::WEIGHT_BITS_DEF,
  localparam int RW         = $clog2(NEURONS),
  localparam int ROW_W      = NEURONS * WEIGHT_BITS
) (
  input  logic               clk,
  input  logic               ld,
  input  logic [RW-1:0]      row_idx,
  input  logic [ROW_W-1:0]   row_data,
  input  logic [NEURONS-1:0] neu,
  output logic               dec
);
  import hamc_pkg::*;

  localparam int NG    = (NEURONS + GROUP - 1) / GROUP;
  localparam int SUM_W = WEIGHT_BITS + $clog2(NEURONS + 2) + 1;

  logic signed [SUM_W-1:0] grp_nxt [NG];
  logic signed [SUM_W-1:0] grp_r   [NG];
  logic signed [SUM_W-1:0] wprev_nxt;
  logic signed [SUM_W-1:0] wprev_r;
  logic [RW-1:0]           pidx;
  logic [RW-1:0]           prev_idx_r;
  logic                    has_prev_r;
  logic                    used_r;
  logic signed [SUM_W-1:0] total;

  assign pidx = row_idx - RW'(1);

  // stage 1: partial sums over groups of neurons
  always_comb begin
    logic signed [WEIGHT_BITS-1:0] w;
    logic signed [SUM_W-1:0]       acc;
    int                            j;
    for (int g = 0; g < NG; g++) begin
      acc = '0;
      for (int k = 0; k < GROUP; k++) begin
        j = g * GROUP + k;
        if (j < NEURONS) begin
          w   = row_data[j*WEIGHT_BITS +: WEIGHT_BITS];
          acc = neu[j] ? acc + SUM_W'(w) : acc - SUM_W'(w);
        end
      end
      grp_nxt[g] = acc;
    end
    w         = row_data[pidx*WEIGHT_BITS +: WEIGHT_BITS];
    wprev_nxt = SUM_W'(w);
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      grp_r      <= grp_nxt;
      wprev_r    <= wprev_nxt;
      prev_idx_r <= pidx;
      has_prev_r <= (row_idx != '0);
      used_r     <= neu[pidx];
    end
  end

  // stage 2: total, fix up the term of the neuron that just settled
  always_comb begin
    total = '0;
    for (int g = 0; g < NG; g++) begin
      total = total + grp_r[g];
    end
    if (has_prev_r && (neu[prev_idx_r] != used_r)) begin
      total = neu[prev_idx_r] ? total + (wprev_r <<< 1) : total - (wprev_r <<< 1);
    end
  end

  assign dec = ~total[SUM_W-1];

endmodule

// ===== rtl/hopfield_associative_memory_core.sv =====
// Hopfield associative memory core: NEURONS bipolar neurons, a row-wide weight
// memory and one row-at-a-time datapath. Clear leaves the block ready. Learn
// streams every weight row through a read-modify-write, and Recall streams the
// rows through a two-stage dot-product unit, one row per cycle, then loads the
// result word once the previous result has been taken; the single memory read
// port, one row per cycle, sets the pace of both. The result sits in an output
// register, so a new word can be taken while it waits.
`include "hopfield_associative_memory_core_macros.svh"

module hopfield_associative_memory_core #(
  parameter int NEURONS     = hamc_pkg::NEURONS_DEF,
  parameter int WEIGHT_BITS = hamc_pkg::WEIGHT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [hamc_pkg::REQ_W-1:0]    in_req_type,
  input  logic [hamc_pkg::PAT_BITS-1:0] in_pattern,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hamc_pkg::PAT_BITS-1:0] out_recalled
);
  import hamc_pkg::*;

  localparam int RW    = $clog2(NEURONS);
  localparam int CW    = $clog2(NEURONS + 1);
  localparam int ROW_W = NEURONS * WEIGHT_BITS;
  localparam int SW    = (NEURONS > PAT_BITS) ? NEURONS : PAT_BITS;

  typedef enum logic [1:0] {S_IDLE, S_LEARN, S_RECALL, S_FIN} state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   iss_r, iss_nxt;
  logic            rd_vld_r, rd_vld_nxt;
  logic [RW-1:0]   rd_row_r, rd_row_nxt;
  logic            s1_vld_r, s1_vld_nxt;
  logic [RW-1:0]   s1_row_r, s1_row_nxt;
  logic [SW-1:0]   st_r, st_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [PAT_BITS-1:0] out_recalled_r, out_recalled_nxt;

  wmem_ctl_t        ctl;
  logic [ROW_W-1:0] rd_data;
  logic [ROW_W-1:0] row_new;
  logic             dec;
  logic             in_acc;

  assign in_ready     = (state_r == S_IDLE);
  assign in_acc       = in_valid && in_ready;
  assign out_valid    = out_valid_r;
  assign out_recalled = out_recalled_r;

  assign ctl.clr = in_acc && (in_req_type == REQ_CLEAR);
  assign ctl.re  = ((state_r == S_LEARN) || (state_r == S_RECALL)) && (iss_r < CW'(NEURONS));
  assign ctl.we  = (state_r == S_LEARN) && rd_vld_r;

  hamc_weight_mem #(
    .NEURONS     (NEURONS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .wr_addr (rd_row_r),
    .wr_data (row_new),
    .rd_addr (iss_r[RW-1:0]),
    .rd_data (rd_data)
  );

  hamc_learn_unit #(
    .NEURONS     (NEURONS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_learn (
    .row_idx  (rd_row_r),
    .row_data (rd_data),
    .neu      (st_r[NEURONS-1:0]),
    .row_new  (row_new)
  );

  hamc_recall_unit #(
    .NEURONS     (NEURONS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_recall (
    .clk      (clk),
    .ld       (rd_vld_r && (state_r == S_RECALL)),
    .row_idx  (rd_row_r),
    .row_data (rd_data),
    .neu      (st_r[NEURONS-1:0]),
    .dec      (dec)
  );

  always_comb begin
    state_nxt        = state_r;
    iss_nxt          = iss_r;
    rd_vld_nxt       = ctl.re;
    rd_row_nxt       = iss_r[RW-1:0];
    s1_vld_nxt       = rd_vld_r && (state_r == S_RECALL);
    s1_row_nxt       = rd_row_r;
    st_nxt           = st_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_recalled_nxt = out_recalled_r;

    if (ctl.re) begin
      iss_nxt = iss_r + CW'(1);
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          st_nxt  = SW'(in_pattern);
          iss_nxt = '0;
          if (in_req_type == REQ_LEARN) begin
            state_nxt = S_LEARN;
          end else if (in_req_type == REQ_RECALL) begin
            state_nxt = S_RECALL;
          end
        end
      end
      S_LEARN: begin
        if (rd_vld_r && (rd_row_r == RW'(NEURONS - 1))) begin
          state_nxt = S_IDLE;
        end
      end
      S_RECALL: begin
        if (s1_vld_r) begin
          st_nxt[s1_row_r] = dec;
          if (s1_row_r == RW'(NEURONS - 1)) begin
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt    = 1'b1;
          out_recalled_nxt = st_r[PAT_BITS-1:0];
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iss_r       <= '0;
      rd_vld_r    <= 1'b0;
      s1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iss_r       <= iss_nxt;
      rd_vld_r    <= rd_vld_nxt;
      s1_vld_r    <= s1_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rd_row_r       <= rd_row_nxt;
    s1_row_r       <= s1_row_nxt;
    st_r           <= st_nxt;
    out_recalled_r <= out_recalled_nxt;
  end

  `HAMC_ASSERT_IMP(a_pipe_order, clk, rst_n, rd_vld_r && s1_vld_r,
                   rd_row_r == (s1_row_r + RW'(1)), "recall pipeline rows out of order")
  `HAMC_ASSERT_NXT(a_busy_after_start, clk, rst_n,
                   in_acc && ((in_req_type == REQ_LEARN) || (in_req_type == REQ_RECALL)),
                   !in_ready, "ready while a learn or recall is under way")
  `HAMC_ASSERT_IMP(a_no_wr_on_clr, clk, rst_n, ctl.we, !ctl.clr,
                   "row write coincides with weight clear")
  `HAMC_ASSERT_IMP(a_s1_in_recall, clk, rst_n, s1_vld_r, state_r == S_RECALL,
                   "dot-product stage active outside recall")

endmodule
